FILE: sv/timer_task_table_assert.svh
// assertion macros for the timer task table checker
// expects clk_i and rst_ni in the scope of each use
`ifndef TIMER_TASK_TABLE_ASSERT_SVH
`define TIMER_TASK_TABLE_ASSERT_SVH

// checked out of reset only
`define TTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define TTT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: sv/ttt_pkg.sv
// shared types and constants of the timer task table
// no dependencies
package ttt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int SLOT_W        = 4;
  localparam int ID_W          = 16;
  localparam int TIME_W        = 32;
  localparam int OP_W          = 3;
  localparam int KIND_W        = 3;

  localparam logic [ID_W-1:0] FIRST_ID = 16'd1;

  typedef enum logic [OP_W-1:0] {
    OPC_TICK     = 3'd0,
    OPC_ONESHOT  = 3'd1,
    OPC_PERIODIC = 3'd2,
    OPC_STOP     = 3'd3,
    OPC_RESTART  = 3'd4
  } op_code_e;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_CREATE,
    CMD_STOP,
    CMD_RESTART
  } cmd_op_e;

  typedef enum logic [KIND_W-1:0] {
    RES_CREATED   = 3'd0,
    RES_NO_FREE   = 3'd1,
    RES_STOPPED   = 3'd2,
    RES_RESTARTED = 3'd3,
    RES_NOT_FOUND = 3'd4,
    RES_FIRED     = 3'd5
  } res_kind_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_DRAIN,
    ENG_FIN
  } eng_state_e;

  // time_ref is the time a create or restart stores, or the tick time
  typedef struct packed {
    cmd_op_e           op;
    logic              periodic;
    logic [TIME_W-1:0] time_ref;
    logic [TIME_W-1:0] interval;
    logic [ID_W-1:0]   task_id;
  } cmd_t;

  typedef struct packed {
    res_kind_e         kind;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
    logic              oneshot;
  } res_t;

endpackage

FILE: sv/timer_task_table.sv
// Timer task table: a bank of NUM_SLOTS one-shot or periodic timer slots with create,
// stop, restart and tick operations. An operation is taken when start_i is high and
// busy_o is low; a two-entry command queue takes up to two operations while the slot
// engine works, and busy_o rises when it is full. Codes 5 to 7 are taken and dropped.
// The engine walks the slot memory through its single read port, one slot per cycle,
// so every operation occupies it while it fetches the command, reads each slot in
// turn, evaluates the last slot and delivers the final beat. Results are strobed for
// a single cycle on result_valid_o and cannot be held off. A tick gives one beat per
// expired slot, at most 16, in slot order, the last one marked by last_o; every other
// operation gives exactly one beat.
// top level, depends on ttt_pkg, ttt_front, ttt_cmd_queue and ttt_engine
module timer_task_table #(
  parameter int NUM_SLOTS = ttt_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ttt_pkg::OP_W-1:0]      operation_i,
  input  logic [ttt_pkg::TIME_W-1:0]    now_ms_i,
  input  logic [ttt_pkg::TIME_W-1:0]    time_value_i,
  input  logic                          start_now_i,
  input  logic [ttt_pkg::ID_W-1:0]      task_id_i,
  output logic                          result_valid_o,
  output logic [ttt_pkg::KIND_W-1:0]    kind_o,
  output logic [ttt_pkg::ID_W-1:0]      result_id_o,
  output logic [ttt_pkg::SLOT_W-1:0]    slot_o,
  output logic                          was_oneshot_o,
  output logic                          last_o
);

  logic          push, full, pop, empty;
  ttt_pkg::cmd_t push_cmd, head_cmd;
  ttt_pkg::res_t res;

  ttt_front u_front (
    .start_i      (start_i),
    .operation_i  (operation_i),
    .now_ms_i     (now_ms_i),
    .time_value_i (time_value_i),
    .start_now_i  (start_now_i),
    .task_id_i    (task_id_i),
    .full_i       (full),
    .busy_o       (busy_o),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  ttt_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_cmd)
  );

  ttt_engine #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .res_last_o  (last_o),
    .res_o       (res)
  );

  assign kind_o        = res.kind;
  assign result_id_o   = res.id;
  assign slot_o        = res.slot;
  assign was_oneshot_o = res.oneshot;

endmodule

FILE: sv/ttt_front.sv
// front end: accepts operations, decodes them into queue commands
// depends on ttt_pkg
module ttt_front (
  input  logic                          start_i,
  input  logic [ttt_pkg::OP_W-1:0]      operation_i,
  input  logic [ttt_pkg::TIME_W-1:0]    now_ms_i,
  input  logic [ttt_pkg::TIME_W-1:0]    time_value_i,
  input  logic                          start_now_i,
  input  logic [ttt_pkg::ID_W-1:0]      task_id_i,
  input  logic                          full_i,
  output logic                          busy_o,
  output logic                          push_o,
  output ttt_pkg::cmd_t                 cmd_o
);

  logic accept;

  assign busy_o = full_i;
  assign accept = start_i & ~full_i;

  always_comb begin
    push_o           = 1'b0;
    cmd_o.op         = ttt_pkg::CMD_TICK;
    cmd_o.periodic   = 1'b0;
    cmd_o.time_ref   = now_ms_i;
    cmd_o.interval   = time_value_i;
    cmd_o.task_id    = task_id_i;
    unique case (ttt_pkg::op_code_e'(operation_i))
      ttt_pkg::OPC_TICK: begin
        push_o = accept;
      end
      ttt_pkg::OPC_ONESHOT: begin
        push_o   = accept;
        cmd_o.op = ttt_pkg::CMD_CREATE;
      end
      ttt_pkg::OPC_PERIODIC: begin
        push_o         = accept;
        cmd_o.op       = ttt_pkg::CMD_CREATE;
        cmd_o.periodic = 1'b1;
        if (start_now_i) begin
          cmd_o.time_ref = '0;
        end
      end
      ttt_pkg::OPC_STOP: begin
        push_o   = accept;
        cmd_o.op = ttt_pkg::CMD_STOP;
      end
      ttt_pkg::OPC_RESTART: begin
        push_o   = accept;
        cmd_o.op = ttt_pkg::CMD_RESTART;
      end
      // unused codes are taken and dropped
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/ttt_cmd_queue.sv
// short command queue between front end and slot engine
// depends on ttt_pkg
module ttt_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ttt_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ttt_pkg::cmd_t head_o
);

  localparam int Depth = ttt_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  ttt_pkg::cmd_t     fifo_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/ttt_engine.sv
// slot engine: scans the slot bank one slot per cycle and emits results
// depends on ttt_pkg
module ttt_engine #(
  parameter int NUM_SLOTS = ttt_pkg::NUM_SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  ttt_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          res_valid_o,
  output logic          res_last_o,
  output ttt_pkg::res_t res_o
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CntW = $clog2(ttt_pkg::MAX_RESULTS + 1);
  localparam int SlotW = ttt_pkg::SLOT_W;

  ttt_pkg::eng_state_e state_q, state_d;

  ttt_pkg::cmd_t  cmd_q;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            eval_v_q;
  logic [IdxW-1:0] eval_idx_q;
  logic [NUM_SLOTS-1:0] active_q, active_d;
  logic [ttt_pkg::ID_W-1:0] next_id_q, next_id_d, id_inc;
  logic            found_q, found_d;
  logic            pend_v_q, pend_v_d;
  ttt_pkg::res_t   pend_q, pend_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            res_v_q, res_v_d;
  logic            res_last_q, res_last_d;
  ttt_pkg::res_t   res_q, res_d;

  // slot memories, read registered at rd_idx_q
  logic [ttt_pkg::TIME_W-1:0] mem_interval [NUM_SLOTS];
  logic [ttt_pkg::TIME_W-1:0] mem_last     [NUM_SLOTS];
  logic [ttt_pkg::ID_W-1:0]   mem_ident    [NUM_SLOTS];
  logic                       mem_periodic [NUM_SLOTS];
  logic [ttt_pkg::TIME_W-1:0] rd_interval_q;
  logic [ttt_pkg::TIME_W-1:0] rd_last_q;
  logic [ttt_pkg::ID_W-1:0]   rd_ident_q;
  logic                       rd_periodic_q;

  logic issue, cur_act, fire, take, hit;
  logic [ttt_pkg::TIME_W-1:0] elapsed;
  logic [IdxW+SlotW-1:0] idx_ext;
  logic [SlotW-1:0] slot_cur;
  ttt_pkg::res_t fire_res;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttt_pkg::ENG_IDLE:  if (!empty_i) state_d = ttt_pkg::ENG_SCAN;
      ttt_pkg::ENG_SCAN:  if (rd_idx_q == IdxW'(NUM_SLOTS - 1)) state_d = ttt_pkg::ENG_DRAIN;
      ttt_pkg::ENG_DRAIN: state_d = ttt_pkg::ENG_FIN;
      ttt_pkg::ENG_FIN:   state_d = ttt_pkg::ENG_IDLE;
      default:            state_d = ttt_pkg::ENG_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o = 1'b0;
    issue = 1'b0;
    unique case (state_q)
      ttt_pkg::ENG_IDLE:  pop_o = !empty_i;
      ttt_pkg::ENG_SCAN:  issue = 1'b1;
      ttt_pkg::ENG_DRAIN: issue = 1'b0;
      ttt_pkg::ENG_FIN:   issue = 1'b0;
      default:            issue = 1'b0;
    endcase
  end

  // evaluation of the slot whose read data is in the rd_* registers
  assign idx_ext  = {{SlotW{1'b0}}, eval_idx_q};
  assign slot_cur = idx_ext[SlotW-1:0];
  assign cur_act  = active_q[eval_idx_q];
  assign elapsed  = cmd_q.time_ref - rd_last_q;

  assign fire = eval_v_q && (cmd_q.op == ttt_pkg::CMD_TICK) && cur_act
                && (elapsed >= rd_interval_q) && (cnt_q != CntW'(ttt_pkg::MAX_RESULTS));
  assign take = eval_v_q && (cmd_q.op == ttt_pkg::CMD_CREATE) && !cur_act && !found_q;
  assign hit  = eval_v_q && ((cmd_q.op == ttt_pkg::CMD_STOP) || (cmd_q.op == ttt_pkg::CMD_RESTART))
                && cur_act && (rd_ident_q == cmd_q.task_id) && !found_q;

  assign id_inc = next_id_q + ttt_pkg::ID_W'(1);

  always_comb begin
    fire_res.kind    = ttt_pkg::RES_FIRED;
    fire_res.id      = rd_ident_q;
    fire_res.slot    = slot_cur;
    fire_res.oneshot = !rd_periodic_q;
  end

  always_comb begin
    rd_idx_d   = rd_idx_q;
    active_d   = active_q;
    next_id_d  = next_id_q;
    found_d    = found_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    res_v_d    = 1'b0;
    res_last_d = 1'b0;
    res_d      = pend_q;

    if (pop_o) begin
      rd_idx_d     = '0;
      found_d      = 1'b0;
      cnt_d        = '0;
      // non-tick items always give one beat; preload the failure
      pend_v_d     = (head_i.op != ttt_pkg::CMD_TICK);
      pend_d.kind  = (head_i.op == ttt_pkg::CMD_CREATE) ? ttt_pkg::RES_NO_FREE
                                                        : ttt_pkg::RES_NOT_FOUND;
      pend_d.id      = '0;
      pend_d.slot    = '0;
      pend_d.oneshot = 1'b0;
    end

    if (issue && (rd_idx_q != IdxW'(NUM_SLOTS - 1))) begin
      rd_idx_d = rd_idx_q + IdxW'(1);
    end

    if (fire) begin
      cnt_d = cnt_q + CntW'(1);
      if (!rd_periodic_q) begin
        active_d[eval_idx_q] = 1'b0;
      end
      // hold one beat back so the last one can be marked
      if (pend_v_q) begin
        res_v_d = 1'b1;
      end
      pend_d   = fire_res;
      pend_v_d = 1'b1;
    end

    if (take) begin
      active_d[eval_idx_q] = 1'b1;
      found_d        = 1'b1;
      pend_d.kind    = ttt_pkg::RES_CREATED;
      pend_d.id      = next_id_q;
      pend_d.slot    = slot_cur;
      pend_d.oneshot = 1'b0;
      next_id_d      = (id_inc == '0) ? ttt_pkg::FIRST_ID : id_inc;
    end

    if (hit) begin
      found_d        = 1'b1;
      pend_d.id      = cmd_q.task_id;
      pend_d.slot    = slot_cur;
      pend_d.oneshot = 1'b0;
      if (cmd_q.op == ttt_pkg::CMD_STOP) begin
        active_d[eval_idx_q] = 1'b0;
        pend_d.kind = ttt_pkg::RES_STOPPED;
      end else begin
        pend_d.kind = ttt_pkg::RES_RESTARTED;
      end
    end

    if ((state_q == ttt_pkg::ENG_FIN) && pend_v_q) begin
      res_v_d    = 1'b1;
      res_last_d = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ttt_pkg::ENG_IDLE;
      rd_idx_q  <= '0;
      eval_v_q  <= 1'b0;
      active_q  <= '0;
      next_id_q <= ttt_pkg::FIRST_ID;
      found_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      cnt_q     <= '0;
      res_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      eval_v_q  <= issue;
      active_q  <= active_d;
      next_id_q <= next_id_d;
      found_q   <= found_d;
      pend_v_q  <= pend_v_d;
      cnt_q     <= cnt_d;
      res_v_q   <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
    eval_idx_q <= rd_idx_q;
    pend_q     <= pend_d;
    res_q      <= res_d;
    res_last_q <= res_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_interval_q <= mem_interval[rd_idx_q];
      rd_last_q     <= mem_last[rd_idx_q];
      rd_ident_q    <= mem_ident[rd_idx_q];
      rd_periodic_q <= mem_periodic[rd_idx_q];
    end
    if (take) begin
      mem_interval[eval_idx_q] <= cmd_q.interval;
      mem_last[eval_idx_q]     <= cmd_q.time_ref;
      mem_ident[eval_idx_q]    <= next_id_q;
      mem_periodic[eval_idx_q] <= cmd_q.periodic;
    end else if (fire || (hit && (cmd_q.op == ttt_pkg::CMD_RESTART))) begin
      mem_last[eval_idx_q] <= cmd_q.time_ref;
    end
  end

  assign res_valid_o = res_v_q;
  assign res_last_o  = res_last_q;
  assign res_o       = res_q;

endmodule

FILE: sv/ttt_checker.sv
// port-level checks of the timer task table, bound to the top level
// depends on ttt_pkg and timer_task_table_assert.svh
`include "timer_task_table_assert.svh"

module ttt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       result_valid_o,
  input logic [ttt_pkg::KIND_W-1:0] kind_o,
  input logic [ttt_pkg::ID_W-1:0]   result_id_o,
  input logic [ttt_pkg::SLOT_W-1:0] slot_o,
  input logic                       was_oneshot_o,
  input logic                       last_o
);

  // only ticks give more than one beat
  `TTT_ASSERT(a_single_beat_last, result_valid_o && (kind_o != ttt_pkg::RES_FIRED) |-> last_o, "non-fired beat not marked last")

  `TTT_ASSERT(a_fail_zero, result_valid_o && (kind_o == ttt_pkg::RES_NO_FREE || kind_o == ttt_pkg::RES_NOT_FOUND) |-> (result_id_o == '0) && (slot_o == '0), "failure beat with id or slot")

  // id 0 is never handed out
  `TTT_ASSERT(a_id_nonzero, result_valid_o && (kind_o == ttt_pkg::RES_CREATED || kind_o == ttt_pkg::RES_STOPPED || kind_o == ttt_pkg::RES_RESTARTED || kind_o == ttt_pkg::RES_FIRED) |-> (result_id_o != '0), "success beat with id zero")

  `TTT_ASSERT(a_oneshot_fired, result_valid_o && was_oneshot_o |-> (kind_o == ttt_pkg::RES_FIRED), "one-shot flag on a non-fired beat")

  `TTT_ASSERT_RST(a_quiet_in_reset, !rst_ni |-> !result_valid_o, "result beat during reset")

endmodule

bind timer_task_table ttt_checker u_ttt_checker (.*);
